// File: src/mmalu_pkg.sv
// ----------------------------------------------------------------------------
// mmalu_pkg
// Shared constants for the 256-bit modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mmalu_pkg;

  localparam int unsigned WORD_W = 256;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CNT_W  = 8;   // bit index over one 256-bit operand

  // group order q
  localparam logic [WORD_W-1:0] MOD_Q = {
    64'd18446744073709551615, 64'd18446744073709551614,
    64'd13451932020343611451, 64'd13822214165235122497};

  // R mod q, R = 2^256
  localparam logic [WORD_W-1:0] MONT_ONE = {
    64'd0, 64'd1, 64'd4994812053365940164, 64'd4624529908474429119};

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SQR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POW = 3'd5;

endpackage

`default_nettype wire

// File: src/mmalu_mont.sv
// ----------------------------------------------------------------------------
// mmalu_mont
// Bit-serial Montgomery multiplier: res = x*y*2^-256 mod q, one bit of x
// per cycle, then one conditional subtract of q.
// ----------------------------------------------------------------------------
`default_nettype none

module mmalu_mont (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mmalu_pkg::WORD_W-1:0] x,
  input  wire logic [mmalu_pkg::WORD_W-1:0] y,
  output logic                             done,
  output logic [mmalu_pkg::WORD_W-1:0]      res
);
  import mmalu_pkg::*;

  logic [WORD_W-1:0] x_r, y_r, res_r;
  logic [WORD_W+1:0] s_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, fin_r, done_r;

  logic              odd;
  logic [WORD_W+2:0] sum;
  logic [WORD_W+2:0] diff;

  // S + x_i*y, plus q when that sum is odd, halved
  assign odd  = s_r[0] ^ (x_r[0] & y_r[0]);
  assign sum  = {1'b0, s_r} + (x_r[0] ? {3'b0, y_r} : '0) + (odd ? {3'b0, MOD_Q} : '0);
  assign diff = {1'b0, s_r} - {3'b0, MOD_Q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r && !fin_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r && !fin_r) begin
      x_r <= x;
      y_r <= y;
      s_r <= '0;
    end else if (busy_r) begin
      x_r <= {1'b0, x_r[WORD_W-1:1]};
      s_r <= sum[WORD_W+2:1];
    end
    if (fin_r) begin
      res_r <= diff[WORD_W+2] ? s_r[WORD_W-1:0] : diff[WORD_W-1:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// File: src/montgomery_mod_alu_256_core.sv
// ----------------------------------------------------------------------------
// montgomery_mod_alu_256_core
// Modular add, sub, neg, Montgomery multiply, square and exponentiation over
// the secp256k1 group order.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | cmd in in_tuser, a0..a3, b0..b3 in in_tdata
//  out_    | out | out_tvalid/out_tready | r0..r3 in out_tdata
//
//  add, sub: adder step, then S_FIX, then S_RES; neg and unknown codes skip S_FIX (wide adder paths).
//  mul, square: one product on the bit-serial multiplier (one bit
//  of the operand per cycle, then a conditional subtract of q).
//  pow: 256 exponent bits, each one or two products.
//  One item at a time; a finished result waits in the output register while
//  the next item is taken. rst_n is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module montgomery_mod_alu_256_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // cmd[2:0]
  input  wire logic [mmalu_pkg::CMD_W-1:0]   in_tuser,
  // a0, a1, a2, a3, b0, b1, b2, b3
  input  wire logic [511:0]                  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // r0, r1, r2, r3
  output logic [255:0]                       out_tdata
);
  import mmalu_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIX   = 3'd1;  // second step of add / sub
  localparam logic [2:0] S_MWAIT = 3'd2;  // mul / square in progress
  localparam logic [2:0] S_PBIT  = 3'd3;  // pow: look at next exponent bit
  localparam logic [2:0] S_PACC  = 3'd4;  // pow: acc * base
  localparam logic [2:0] S_PSQ   = 3'd5;  // pow: base * base
  localparam logic [2:0] S_RES   = 3'd6;  // result waits for output register

  logic [2:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [WORD_W:0]   w_r, w_nxt;            // add/sub intermediate, 257 bits
  logic [WORD_W-1:0] acc_r, acc_nxt, base_r, base_nxt, exp_r, exp_nxt;
  logic [CNT_W-1:0]  bit_r, bit_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  logic [CMD_W-1:0]  in_cmd;
  logic [WORD_W-1:0] in_a, in_b;
  logic [WORD_W+1:0] add_diff;

  logic              m_start, m_done;
  logic [WORD_W-1:0] m_x, m_y, m_res;

  assign in_cmd = in_tuser;
  assign in_a   = in_tdata[255:0];
  assign in_b   = in_tdata[511:256];

  assign in_tready = (state_r == S_IDLE);

  // sum minus q: no borrow means the sum is at least q
  assign add_diff = {1'b0, w_r} - {2'b0, MOD_Q};

  mmalu_mont u_mont (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .x     (m_x),
    .y     (m_y),
    .done  (m_done),
    .res   (m_res)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    w_nxt     = w_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    bit_nxt   = bit_r;
    res_nxt   = res_r;
    m_start   = 1'b0;
    m_x       = acc_r;
    m_y       = base_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_cmd;
          case (in_cmd)
            CMD_ADD: begin
              w_nxt     = {1'b0, in_a} + {1'b0, in_b};
              state_nxt = S_FIX;
            end
            CMD_SUB: begin
              // bit 256 set means a < b
              w_nxt     = {1'b0, in_a} - {1'b0, in_b};
              state_nxt = S_FIX;
            end
            CMD_NEG: begin
              res_nxt   = MOD_Q - in_a;
              state_nxt = S_RES;
            end
            CMD_MUL, CMD_SQR: begin
              m_start   = 1'b1;
              m_x       = in_a;
              m_y       = (in_cmd == CMD_MUL) ? in_b : in_a;
              state_nxt = S_MWAIT;
            end
            CMD_POW: begin
              acc_nxt   = MONT_ONE;
              base_nxt  = in_a;
              exp_nxt   = in_b;
              bit_nxt   = '0;
              state_nxt = S_PBIT;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_FIX: begin
        if (cmd_r == CMD_ADD) begin
          res_nxt = add_diff[WORD_W+1] ? w_r[WORD_W-1:0] : add_diff[WORD_W-1:0];
        end else begin
          // a < b: (q - b) + a == (a - b) + q mod 2^256
          res_nxt = w_r[WORD_W] ? (w_r[WORD_W-1:0] + MOD_Q) : w_r[WORD_W-1:0];
        end
        state_nxt = S_RES;
      end
      S_MWAIT: begin
        if (m_done) begin
          res_nxt   = m_res;
          state_nxt = S_RES;
        end
      end
      S_PBIT: begin
        m_start = 1'b1;
        if (exp_r[0]) begin
          state_nxt = S_PACC;
        end else begin
          m_x       = base_r;
          state_nxt = S_PSQ;
        end
      end
      S_PACC: begin
        if (m_done) begin
          acc_nxt   = m_res;
          m_start   = 1'b1;
          m_x       = base_r;
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        if (m_done) begin
          base_nxt = m_res;
          exp_nxt  = {1'b0, exp_r[WORD_W-1:1]};
          bit_nxt  = bit_r + 1'b1;
          if (bit_r == CNT_W'(WORD_W - 1)) begin
            res_nxt   = acc_r;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_PBIT;
          end
        end
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RES && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    w_r    <= w_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    if (state_r == S_RES && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
